FILE: design/bhpq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int PRIO_W = 16;
  localparam int FILL_W = 7;

  // Request kinds.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PRIO_W-1:0] min_value;
    logic [FILL_W-1:0] fill_level;
  } out_result_t;

  // Contents of one storage cell as seen by its neighbours.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] value;
  } slot_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic              ins;
    logic              ext;
    logic [PRIO_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: design/binary_min_heap_priority_queue_top.sv
// Top level of the min-priority queue: a sorted row of cells and the result register.
// The result strobe comes in the cycle after the request is accepted; no new request
// is taken while the result is shown. Every cell updates in the accept cycle
// and busy stays high for the single cycle in which the result is shown.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the queue and clears busy and the strobe.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_priority_queue_top
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_strobe,
  output out_result_t  out_result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             busy_r;
  logic             strobe_r;
  out_result_t      result_r;
  out_result_t      result_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  cell_cmd_t cmd;

  slot_t                slots [CAPACITY];
  logic  [CAPACITY-1:0] lts;
  logic  [CAPACITY-1:0] valid_vec;

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  assign cmd.ins   = accept && (in_req.req_type == REQ_INSERT) && !full;
  assign cmd.ext   = accept && (in_req.req_type == REQ_EXTRACT) && !empty;
  assign cmd.value = in_req.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    logic  left_lt;
    slot_t right_slot;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_lt   = 1'b0;
    end else begin : g_body
      assign left_slot = slots[i-1];
      assign left_lt   = lts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    bhpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .left_lt    (left_lt),
      .right_slot (right_slot),
      .slot       (slots[i]),
      .lt         (lts[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  always_comb begin
    count_nxt             = count_r;
    result_nxt.status     = ST_INSERTED;
    result_nxt.min_value  = '0;
    if (in_req.req_type == REQ_INSERT) begin
      if (full) begin
        result_nxt.status = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        result_nxt.status = ST_EMPTY;
      end else begin
        result_nxt.status    = ST_EXTRACTED;
        result_nxt.min_value = slots[0].value;
        count_nxt            = count_r - 1'b1;
      end
    end
    result_nxt.fill_level = FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= accept;
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_result = result_r;

`ifndef SYNTHESIS
  // Every accepted request yields its result in the very next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> strobe_r)
    else $error("result strobe missing after an accepted request");

  // The occupied cells always match the job count.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("job count disagrees with occupied cells");

  // If any cell behind the head is occupied, the head cell is occupied too.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec[CAPACITY-1:1] != '0 |-> valid_vec[0])
    else $error("hole at the head of the cell row");

  // The head cell holds a value no larger than that of the second cell.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (slots[0].valid && slots[1].valid) |-> (slots[0].value <= slots[1].value))
    else $error("head cell is not the minimum");
`endif

endmodule

`default_nettype wire

FILE: design/bhpq_cell.sv
// One cell of the sorted row: holds a single priority and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_cell
  import bhpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire slot_t     left_slot,
  input  wire logic      left_lt,
  input  wire slot_t     right_slot,
  output slot_t          slot,
  output logic           lt
);

  logic              valid_r;
  logic              valid_nxt;
  logic [PRIO_W-1:0] value_r;
  logic [PRIO_W-1:0] value_nxt;

  // An empty cell counts as holding infinity, so any new value sorts ahead of it.
  assign lt = !valid_r || (cmd.value < value_r);

  assign slot.valid = valid_r;
  assign slot.value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.ins && lt) begin
      // The new value lands in the first cell that is empty or holds a larger one;
      // every cell behind it takes its left neighbour's contents.
      if (left_lt) begin
        valid_nxt = left_slot.valid;
        value_nxt = left_slot.value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = cmd.value;
      end
    end else if (cmd.ext) begin
      valid_nxt = right_slot.valid;
      value_nxt = right_slot.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire
